// ===== hw/rtl/assert_macros.svh =====
// Assertion helper macros for the BGRA to YUV 4:2:0 converter.
// Included by the top level; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition on every clock edge outside reset.
`define B2Y_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("b2y assertion failed");

// Check that a condition leads to another one on the next edge.
`define B2Y_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("b2y assertion failed");

`endif

// ===== hw/rtl/b2y_pkg.sv =====
// Shared types and constants of the BGRA to YUV 4:2:0 converter.
// No dependencies; imported by every module of the block.
package b2y_pkg;

   localparam int PIX_W     = 8;
   localparam int SUM_W     = 9;
   localparam int QUAD_W    = 10;
   localparam int CFG_W     = 12;
   localparam int ROW_W     = 11;
   localparam int CSR_IDX_W = 1;
   localparam int HEIGHT_LIMIT = 2048;

   localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 12'd640;
   localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd480;

   // Q16 coefficients with the studio-range scale folded in
   localparam logic [15:0] Y_R  = 16'd12840;
   localparam logic [15:0] Y_G  = 16'd35452;
   localparam logic [15:0] Y_B  = 16'd4361;
   localparam logic [15:0] CB_R = 16'd10408;
   localparam logic [15:0] CB_G = 16'd20432;
   localparam logic [15:0] CB_B = 16'd30840;
   localparam logic [15:0] CR_R = 16'd30840;
   localparam logic [15:0] CR_G = 16'd25825;
   localparam logic [15:0] CR_B = 16'd5015;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } b2y_csr_type;

   // Blue sits in the low bits, as in the line store layout
   typedef struct packed {
      logic [SUM_W-1:0] red;
      logic [SUM_W-1:0] green;
      logic [SUM_W-1:0] blue;
   } b2y_pair_type;

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
   } b2y_pixel_type;

   typedef struct packed {
      logic valid;
      logic chroma;
      logic last;
   } b2y_tag_type;

endpackage

// ===== hw/rtl/bgra_to_yuv420_converter.sv =====
// Top level of the BGRA to YUV 4:2:0 converter: counters, config, line
// store control, stage tags and output register. Uses b2y_pkg and the
// b2y_line_store, b2y_luma and b2y_chroma modules; asserts via assert_macros.svh.
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | req_blue, req_green, req_red
//   rsp     | out       | rsp_valid/rsp_stall | rsp_luma, rsp_chroma_valid,
//           |           |                     | rsp_cb_sample, rsp_cr_sample, rsp_frame_end
//   csr     | in        | csr_valid/csr_ready | csr_index, csr_wdata
//
// One pixel per cycle sustained while rsp_stall does not hold the output; a beat goes
// through the input register and line-store read, product stage, sum stage and output
// register to rsp. The whole pipeline freezes while a result waits under rsp_stall.
// Reset clears counters and stage valids and loads the size registers (640 x 480);
// the line store is not cleared, every odd row reads entries of the row above.
module bgra_to_yuv420_converter #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [b2y_pkg::PIX_W-1:0]   req_blue,
   input  logic [b2y_pkg::PIX_W-1:0]   req_green,
   input  logic [b2y_pkg::PIX_W-1:0]   req_red,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [b2y_pkg::PIX_W-1:0]   rsp_luma,
   output logic                        rsp_chroma_valid,
   output logic [b2y_pkg::PIX_W-1:0]   rsp_cb_sample,
   output logic [b2y_pkg::PIX_W-1:0]   rsp_cr_sample,
   output logic                        rsp_frame_end,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [b2y_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [b2y_pkg::CFG_W-1:0]   csr_wdata
);
   import b2y_pkg::*;
   `include "assert_macros.svh"

   localparam int WIDTH_LIMIT = (MAX_WIDTH / 2) * 2;
   localparam int LINE_DEPTH  = MAX_WIDTH / 2;
   localparam int ADDR_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
   localparam int COL_W       = ($clog2(MAX_WIDTH) > 2) ? $clog2(MAX_WIDTH) : 2;

   function automatic logic [COL_W-1:0] width_last(input logic [CFG_W-1:0] v);
      int e;
      e = int'({v[CFG_W-1:1], 1'b0});
      if (e > WIDTH_LIMIT) e = WIDTH_LIMIT;
      if (e < 2) e = 2;
      return COL_W'(e - 1);
   endfunction

   function automatic logic [ROW_W-1:0] height_last(input logic [CFG_W-1:0] v);
      int e;
      e = int'({v[CFG_W-1:1], 1'b0});
      if (e > HEIGHT_LIMIT) e = HEIGHT_LIMIT;
      if (e < 2) e = 2;
      return ROW_W'(e - 1);
   endfunction

   logic [COL_W-1:0] width_last_ff, col_ff, col_in;
   logic [ROW_W-1:0] height_last_ff, row_ff, row_in;
   b2y_pixel_type    hold_ff, pixel_in, pix1_ff;
   b2y_pair_type     pair_in, pair1_ff, line_rd;
   b2y_tag_type      tag_in, tag1_ff, tag2_ff, tag3_ff;
   logic             advance, accept, frame_last, row_wrap;
   logic             line_wr, line_rd_en;
   logic [ADDR_W-1:0] line_addr;
   logic [PIX_W-1:0] luma3, cb3, cr3;

   logic             rsp_valid_ff, rsp_chroma_ff, rsp_last_ff;
   logic [PIX_W-1:0] rsp_luma_ff, rsp_cb_ff, rsp_cr_ff;

   // the pipeline moves whenever the output slot is free or being taken
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign accept    = req_valid && advance;
   assign req_stall = !advance;
   assign csr_ready = 1'b1;

   always_comb begin
      pixel_in   = '{red: req_red, green: req_green, blue: req_blue};
      pair_in    = '{red:   SUM_W'(req_red)   + SUM_W'(hold_ff.red),
                     green: SUM_W'(req_green) + SUM_W'(hold_ff.green),
                     blue:  SUM_W'(req_blue)  + SUM_W'(hold_ff.blue)};
      line_addr  = ADDR_W'(col_ff >> 1);
      line_wr    = accept && col_ff[0] && !row_ff[0];
      line_rd_en = accept && col_ff[0] && row_ff[0];
      row_wrap   = (col_ff == width_last_ff);
      frame_last = row_wrap && (row_ff == height_last_ff);
      col_in     = row_wrap ? '0 : col_ff + COL_W'(1);
      if (!row_wrap) begin
         row_in = row_ff;
      end else if (frame_last) begin
         row_in = '0;
      end else begin
         row_in = row_ff + ROW_W'(1);
      end
      tag_in = '{valid: accept, chroma: line_rd_en, last: frame_last};
   end

   // size registers and position counters; a size write restarts the frame
   always_ff @(posedge clock) begin
      if (reset) begin
         width_last_ff  <= width_last(FRAME_WIDTH_RST);
         height_last_ff <= height_last(FRAME_HEIGHT_RST);
         col_ff         <= '0;
         row_ff         <= '0;
         hold_ff        <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FRAME_WIDTH: begin
               width_last_ff <= width_last(csr_wdata);
            end
            CSR_FRAME_HEIGHT: begin
               height_last_ff <= height_last(csr_wdata);
            end
            default: begin
            end
         endcase
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         hold_ff <= pixel_in;
      end
   end

   b2y_line_store #(
      .DEPTH  (LINE_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (line_wr),
      .wr_addr (line_addr),
      .wr_data (pair_in),
      .rd_en   (line_rd_en),
      .rd_addr (line_addr),
      .rd_data (line_rd)
   );

   b2y_luma u_luma (
      .clock  (clock),
      .enable (advance),
      .pixel  (pix1_ff),
      .luma   (luma3)
   );

   b2y_chroma u_chroma (
      .clock      (clock),
      .enable     (advance),
      .pair_now   (pair1_ff),
      .pair_above (line_rd),
      .cb         (cb3),
      .cr         (cr3)
   );

   always_ff @(posedge clock) begin
      if (advance) begin
         pix1_ff     <= pixel_in;
         pair1_ff    <= pair_in;
         rsp_luma_ff <= luma3;
         rsp_cb_ff   <= tag3_ff.chroma ? cb3 : '0;
         rsp_cr_ff   <= tag3_ff.chroma ? cr3 : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff       <= '0;
         tag2_ff       <= '0;
         tag3_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         rsp_chroma_ff <= 1'b0;
         rsp_last_ff   <= 1'b0;
      end else if (advance) begin
         tag1_ff       <= tag_in;
         tag2_ff       <= tag1_ff;
         tag3_ff       <= tag2_ff;
         rsp_valid_ff  <= tag3_ff.valid;
         rsp_chroma_ff <= tag3_ff.chroma;
         rsp_last_ff   <= tag3_ff.last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_luma         = rsp_luma_ff;
   assign rsp_chroma_valid = rsp_chroma_ff;
   assign rsp_cb_sample    = rsp_cb_ff;
   assign rsp_cr_sample    = rsp_cr_ff;
   assign rsp_frame_end    = rsp_last_ff;

   `B2Y_ASSERT_ALWAYS(a_col_in_row, clock, reset, col_ff <= width_last_ff)
   `B2Y_ASSERT_ALWAYS(a_row_in_frame, clock, reset, row_ff <= height_last_ff)
   `B2Y_ASSERT_NEXT(a_frame_wrap, clock, reset, accept && frame_last, col_ff == '0 && row_ff == '0)
   `B2Y_ASSERT_NEXT(a_chroma_odd, clock, reset, line_rd_en, tag1_ff.valid && tag1_ff.chroma)

endmodule

// ===== hw/rtl/b2y_line_store.sv =====
// Line store of even-row pair sums, one entry per column pair.
// Synchronous memory with a registered read. Uses b2y_pkg.
module b2y_line_store #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  b2y_pkg::b2y_pair_type wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_W-1:0]     rd_addr,
   output b2y_pkg::b2y_pair_type rd_data
);
   import b2y_pkg::*;

   b2y_pair_type mem [DEPTH];
   b2y_pair_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/b2y_luma.sv =====
// Two-stage luma datapath: registered products, then sum, offset, saturate.
// Uses b2y_pkg for the Q16 coefficients.
module b2y_luma (
   input  logic                   clock,
   input  logic                   enable,
   input  b2y_pkg::b2y_pixel_type pixel,
   output logic [b2y_pkg::PIX_W-1:0] luma
);
   import b2y_pkg::*;

   logic [23:0]      prod_r_ff, prod_g_ff, prod_b_ff;
   logic [24:0]      sum;
   logic [PIX_W-1:0] luma_in, luma_ff;

   always_comb begin
      sum = 25'(prod_r_ff) + 25'(prod_g_ff) + 25'(prod_b_ff) + 25'(1 << 20);
      luma_in = (sum[24:16] > 9'd255) ? 8'd255 : sum[23:16];
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_r_ff <= 24'(Y_R) * 24'(pixel.red);
         prod_g_ff <= 24'(Y_G) * 24'(pixel.green);
         prod_b_ff <= 24'(Y_B) * 24'(pixel.blue);
         luma_ff   <= luma_in;
      end
   end

   assign luma = luma_ff;

endmodule

// ===== hw/rtl/b2y_chroma.sv =====
// Chroma datapath: 2x2 component sums, registered products, then the
// signed sums with offset and clamp (unregistered output). Uses b2y_pkg.
module b2y_chroma (
   input  logic                      clock,
   input  logic                      enable,
   input  b2y_pkg::b2y_pair_type     pair_now,
   input  b2y_pkg::b2y_pair_type     pair_above,
   output logic [b2y_pkg::PIX_W-1:0] cb,
   output logic [b2y_pkg::PIX_W-1:0] cr
);
   import b2y_pkg::*;

   logic [QUAD_W-1:0] sum_b_ff, sum_g_ff, sum_r_ff;
   logic [24:0] cb_b_ff, cb_g_ff, cb_r_ff;
   logic [24:0] cr_b_ff, cr_g_ff, cr_r_ff;
   logic signed [27:0] cb_acc, cr_acc;

   function automatic logic [PIX_W-1:0] clamp_byte(input logic signed [27:0] acc);
      logic [9:0] v;
      v = acc[27:18];
      if (acc[27]) begin
         return '0;
      end else if (v > 10'd255) begin
         return 8'd255;
      end else begin
         return v[PIX_W-1:0];
      end
   endfunction

   always_comb begin
      cb_acc = $signed({3'b000, cb_b_ff}) - $signed({3'b000, cb_r_ff})
             - $signed({3'b000, cb_g_ff}) + $signed(28'(128 << 18));
      cr_acc = $signed({3'b000, cr_r_ff}) - $signed({3'b000, cr_g_ff})
             - $signed({3'b000, cr_b_ff}) + $signed(28'(128 << 18));
      cb = clamp_byte(cb_acc);
      cr = clamp_byte(cr_acc);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         sum_b_ff <= QUAD_W'(pair_now.blue)  + QUAD_W'(pair_above.blue);
         sum_g_ff <= QUAD_W'(pair_now.green) + QUAD_W'(pair_above.green);
         sum_r_ff <= QUAD_W'(pair_now.red)   + QUAD_W'(pair_above.red);
         cb_b_ff  <= 25'(CB_B) * 25'(sum_b_ff);
         cb_g_ff  <= 25'(CB_G) * 25'(sum_g_ff);
         cb_r_ff  <= 25'(CB_R) * 25'(sum_r_ff);
         cr_b_ff  <= 25'(CR_B) * 25'(sum_b_ff);
         cr_g_ff  <= 25'(CR_G) * 25'(sum_g_ff);
         cr_r_ff  <= 25'(CR_R) * 25'(sum_r_ff);
      end
   end

endmodule
